[rtl/swrl_pkg.sv]
// Shared types, sizes and helpers for the sliding window rate limiter.
`default_nettype none

package swrl_pkg;

    localparam int SERVICES    = 16;
    localparam int MAX_LIMIT   = 16;
    localparam int RING_TOTAL  = 4 * SERVICES;
    localparam int STORE_DEPTH = RING_TOTAL * MAX_LIMIT;

    localparam int SVC_W    = (SERVICES > 1) ? $clog2(SERVICES) : 1;
    localparam int RING_W   = $clog2(RING_TOTAL);
    localparam int HEAD_W   = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
    localparam int CNT_W    = $clog2(MAX_LIMIT + 1);
    localparam int STORE_AW = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(1);

    localparam logic [31:0] WINDOW_RESET = 32'd10;
    localparam logic [4:0]  LIMIT_RESET  = 5'd5;

    typedef struct packed {
        logic [3:0]  service_index;
        logic        lat_negative;
        logic        lon_negative;
        logic [31:0] now_seconds;
    } request_t;

    typedef struct packed {
        logic       allowed;
        logic [1:0] quadrant;
        logic [4:0] ring_fill;
    } result_t;

    typedef struct packed {
        logic [31:0] window_seconds;
        logic [4:0]  limit_count;
    } cfg_t;

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [CNT_W-1:0]  count;
    } ring_entry_t;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [31:0]         wdata;
    } stamp_req_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [RING_W-1:0] addr;
        ring_entry_t       wdata;
    } ring_req_t;

    // service index wraps modulo SERVICES; small lookup over the 16 codes
    function automatic logic [SVC_W-1:0] svc_wrap(input logic [3:0] s);
        logic [SVC_W-1:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (s == 4'(i)) begin
                r = SVC_W'(i % SERVICES);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/swrl_ram.sv]
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/swrl_ctrl.sv]
// Request sequencer: reads ring state, pops expired stamps, decides and writes back.
`default_nettype none

module swrl_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire swrl_pkg::request_t   request,
    input  wire swrl_pkg::cfg_t       cfg,
    output logic                      done,
    output swrl_pkg::result_t         result,
    output swrl_pkg::stamp_req_t      stamp_req,
    input  wire logic [31:0]          stamp_rdata,
    output swrl_pkg::ring_req_t       ring_req,
    input  wire swrl_pkg::ring_entry_t ring_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RING,
        ST_STAMP,
        ST_DECIDE
    } state_t;

    state_t                             state_reg, state_next;
    logic [swrl_pkg::RING_W-1:0]        ring_reg, ring_next;
    logic [1:0]                         quad_reg, quad_next;
    logic [31:0]                        now_reg, now_next;
    logic [swrl_pkg::HEAD_W-1:0]        head_reg, head_next;
    logic [swrl_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [swrl_pkg::CNT_W-1:0]         lim_reg, lim_next;
    logic [swrl_pkg::RING_TOTAL-1:0]    valid_reg, valid_next;
    logic                               done_reg, done_next;
    swrl_pkg::result_t                  result_reg, result_next;

    swrl_pkg::ring_entry_t              entry;
    logic [swrl_pkg::RING_W-1:0]        req_ring;
    logic [31:0]                        age;
    logic [swrl_pkg::HEAD_W-1:0]        head_inc;
    logic [swrl_pkg::CNT_W-1:0]         count_dec;
    logic [swrl_pkg::HEAD_W:0]          slot_sum;
    logic [swrl_pkg::HEAD_W-1:0]        slot;
    logic                               admit;

    function automatic logic [swrl_pkg::STORE_AW-1:0] stamp_addr(
        input logic [swrl_pkg::RING_W-1:0] ring,
        input logic [swrl_pkg::HEAD_W-1:0] pos
    );
        return swrl_pkg::STORE_AW'(int'(ring) * swrl_pkg::MAX_LIMIT + int'(pos));
    endfunction

    assign req_ring = swrl_pkg::RING_W'({swrl_pkg::svc_wrap(request.service_index),
                                         request.lat_negative, request.lon_negative});
    assign entry = valid_reg[ring_reg] ? ring_rdata : '0;
    assign age = now_reg - stamp_rdata;
    assign head_inc = (int'(head_reg) == swrl_pkg::MAX_LIMIT - 1) ? '0 : head_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign slot_sum = (swrl_pkg::HEAD_W + 1)'(head_reg) + (swrl_pkg::HEAD_W + 1)'(count_reg);
    assign slot = (int'(slot_sum) >= swrl_pkg::MAX_LIMIT)
                ? swrl_pkg::HEAD_W'(int'(slot_sum) - swrl_pkg::MAX_LIMIT)
                : swrl_pkg::HEAD_W'(slot_sum);
    assign admit = count_reg < lim_reg;

    always_comb
    begin
        state_next  = state_reg;
        ring_next   = ring_reg;
        quad_next   = quad_reg;
        now_next    = now_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        lim_next    = lim_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        stamp_req   = '0;
        ring_req    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ring_next = req_ring;
                    quad_next = {request.lat_negative, request.lon_negative};
                    now_next  = request.now_seconds;
                    if (int'(cfg.limit_count) > swrl_pkg::MAX_LIMIT)
                    begin
                        lim_next = swrl_pkg::CNT_W'(swrl_pkg::MAX_LIMIT);
                    end
                    else
                    begin
                        lim_next = swrl_pkg::CNT_W'(cfg.limit_count);
                    end
                    ring_req.en   = 1'b1;
                    ring_req.addr = req_ring;
                    state_next    = ST_RING;
                end
            end
            ST_RING:
            begin
                head_next  = entry.head;
                count_next = entry.count;
                if (entry.count != '0)
                begin
                    stamp_req.en   = 1'b1;
                    stamp_req.addr = stamp_addr(ring_reg, entry.head);
                    state_next     = ST_STAMP;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_STAMP:
            begin
                if (age > cfg.window_seconds)
                begin
                    head_next  = head_inc;
                    count_next = count_dec;
                    if (count_dec != '0)
                    begin
                        stamp_req.en   = 1'b1;
                        stamp_req.addr = stamp_addr(ring_reg, head_inc);
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (admit)
                begin
                    stamp_req.en    = 1'b1;
                    stamp_req.we    = 1'b1;
                    stamp_req.addr  = stamp_addr(ring_reg, slot);
                    stamp_req.wdata = now_reg;
                end
                ring_req.en          = 1'b1;
                ring_req.we          = 1'b1;
                ring_req.addr        = ring_reg;
                ring_req.wdata.head  = head_reg;
                ring_req.wdata.count = admit ? count_reg + 1'b1 : count_reg;
                valid_next[ring_reg] = 1'b1;
                done_next             = 1'b1;
                result_next.allowed   = admit;
                result_next.quadrant  = quad_reg;
                result_next.ring_fill = 5'(admit ? count_reg + 1'b1 : count_reg);
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ring_reg   <= '0;
            quad_reg   <= '0;
            now_reg    <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            lim_reg    <= '0;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ring_reg   <= ring_next;
            quad_reg   <= quad_next;
            now_reg    <= now_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            lim_reg    <= lim_next;
            valid_reg  <= valid_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/sliding_window_rate_limiter_top.sv]
// Top level of the sliding window rate limiter: config registers, memories, sequencer.
//
// A request is taken when start is high and busy is low. The ring state (head and
// fill of the selected ring) is read first, then the timestamp memory is read one
// stamp per cycle from the front of the ring until a live stamp is met or the ring
// runs empty, then the decide state writes back. busy stays high through the ring
// read, the k stamp reads (k from 0 to MAX_LIMIT) and the decide state; the single
// timestamp memory port is why the stamps are read one at a time. The result shows
// on result for the one cycle done is high, in the same cycle that busy falls, and
// a new request may be started in that same cycle. Results cannot be held off. No
// clearing pass is needed after reset. Write window_seconds (index 0) and
// limit_count (index 1) only while busy is low.
`default_nettype none

module sliding_window_rate_limiter_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire swrl_pkg::request_t                 request,
    output logic                                    done,
    output swrl_pkg::result_t                       result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [swrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_data
);

    swrl_pkg::cfg_t        cfg_reg, cfg_next;
    swrl_pkg::stamp_req_t  stamp_req;
    swrl_pkg::ring_req_t   ring_req;
    logic [31:0]           stamp_rdata;
    swrl_pkg::ring_entry_t ring_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                swrl_pkg::CFG_WINDOW: cfg_next.window_seconds = cfg_data;
                swrl_pkg::CFG_LIMIT:  cfg_next.limit_count    = cfg_data[4:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_seconds <= swrl_pkg::WINDOW_RESET;
            cfg_reg.limit_count    <= swrl_pkg::LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    swrl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .cfg         (cfg_reg),
        .done        (done),
        .result      (result),
        .stamp_req   (stamp_req),
        .stamp_rdata (stamp_rdata),
        .ring_req    (ring_req),
        .ring_rdata  (ring_rdata)
    );

    swrl_ram #(
        .WIDTH (32),
        .DEPTH (swrl_pkg::STORE_DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .en    (stamp_req.en),
        .we    (stamp_req.we),
        .addr  (stamp_req.addr),
        .wdata (stamp_req.wdata),
        .rdata (stamp_rdata)
    );

    swrl_ram #(
        .WIDTH ($bits(swrl_pkg::ring_entry_t)),
        .DEPTH (swrl_pkg::RING_TOTAL)
    ) u_ring_ram (
        .clk   (clk),
        .en    (ring_req.en),
        .we    (ring_req.we),
        .addr  (ring_req.addr),
        .wdata (ring_req.wdata),
        .rdata (ring_rdata)
    );

endmodule

`default_nettype wire

[rtl/swrl_checker.sv]
// Port-level assertions for the rate limiter top, attached by bind.
`default_nettype none

module swrl_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire swrl_pkg::result_t result
);

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a request in progress");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result beats in a row");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && (result.allowed == 1'b0 || result.ring_fill != 5'd0)))
        else $error("result beat while busy or admitted with empty ring");

endmodule

bind sliding_window_rate_limiter_top swrl_checker u_checker (.*);

`default_nettype wire

[sim/admission_checker.sv]
// Checker for the rate limiter: tracks rings per request, predicts each verdict, compares results.
module admission_checker
    import swrl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  request_t             request,
    input  logic                 done,
    input  result_t              result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   errors,
    output int                   pending,
    output int                   admitted,
    output int                   refused
);

    logic [31:0] stamp_mem [STORE_DEPTH];
    int          ring_front [RING_TOTAL];
    int          ring_fill  [RING_TOTAL];
    logic [31:0] window_q;
    logic [4:0]  limit_q;

    result_t     pending_verdicts [$];
    int          fail_count  = 0;
    int          admit_count = 0;
    int          refuse_count = 0;

    // expire old stamps at the ring front, then admit if room is left
    function automatic result_t admit_request(input request_t req);
        int          svc;
        int          quad;
        int          ring;
        int          base;
        int          front;
        int          fill;
        int          lim;
        logic [31:0] age;
        result_t     verdict;
        svc   = int'(req.service_index) % SERVICES;
        quad  = int'({req.lat_negative, req.lon_negative});
        ring  = svc * 4 + quad;
        base  = ring * MAX_LIMIT;
        front = ring_front[ring];
        fill  = ring_fill[ring];
        lim   = (int'(limit_q) > MAX_LIMIT) ? MAX_LIMIT : int'(limit_q);
        verdict = '0;
        while (fill > 0)
        begin
            age = req.now_seconds - stamp_mem[base + front];
            if (age <= window_q)
                break;
            front = (front + 1) % MAX_LIMIT;
            fill--;
        end
        if (fill < lim)
        begin
            stamp_mem[base + (front + fill) % MAX_LIMIT] = req.now_seconds;
            fill++;
            verdict.allowed = 1'b1;
        end
        ring_front[ring]  = front;
        ring_fill[ring]   = fill;
        verdict.quadrant  = quad[1:0];
        verdict.ring_fill = fill[4:0];
        return verdict;
    endfunction

    task automatic compare_field(input string field, input logic [4:0] want,
                                 input logic [4:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            window_q = WINDOW_RESET;
            limit_q  = LIMIT_RESET;
            for (int r = 0; r < RING_TOTAL; r++)
            begin
                ring_front[r] = 0;
                ring_fill[r]  = 0;
            end
            pending_verdicts.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, actual %b/%0d/%0d",
                             $time, result.allowed, result.quadrant, result.ring_fill);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    compare_field("allowed", want.allowed, result.allowed);
                    compare_field("quadrant", want.quadrant, result.quadrant);
                    compare_field("ring_fill", want.ring_fill, result.ring_fill);
                    if (result.allowed === 1'b1)
                        admit_count++;
                    else
                        refuse_count++;
                end
            end
            if (start && !busy)
            begin
                fresh = admit_request(request);
                pending_verdicts.insert(pending_verdicts.size(), fresh);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WINDOW)
                    window_q = cfg_data;
                else if (cfg_index == CFG_LIMIT)
                    limit_q = cfg_data[4:0];
            end
            pending <= pending_verdicts.size();
        end
        errors   <= fail_count;
        admitted <= admit_count;
        refused  <= refuse_count;
    end

endmodule

[sim/tb_top.sv]
// Testbench top for the rate limiter: clock, reset, request and settings stimulus, verdict.
module tb_top;
    import swrl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 150;
    localparam int HOT_RINGS   = 3;
    localparam int STALL_LIMIT = 2000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    request_t             request   = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 busy;
    logic                 done;
    logic                 cfg_ready;
    result_t              result;

    int errors;
    int pending;
    int admitted;
    int refused;

    int idle_pct       = 13;
    int sent           = 0;
    int settings_count = 0;
    int stall_cycles   = 0;

    sliding_window_rate_limiter_top u_top (
        .clk, .rst_n, .start, .busy, .request, .done, .result,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    admission_checker u_checker (
        .clk, .rst_n, .start, .busy, .request, .done, .result,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .pending, .admitted, .refused
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // watchdog: any accepted beat on any channel counts as progress
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("sliding_window_rate_limiter_top regression: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic request_t make_req(input logic [3:0] svc, input logic latn,
                                          input logic lonn, input logic [31:0] now);
        request_t r;
        r.service_index = svc;
        r.lat_negative  = latn;
        r.lon_negative  = lonn;
        r.now_seconds   = now;
        return r;
    endfunction

    // start stays high from one request to the next unless an idle gap is drawn
    task automatic send_request(input request_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    task automatic wait_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // both registers in random order; optionally a beat to the unused index
    task automatic load_settings(input logic [31:0] window, input logic [4:0] limit,
                                 input bit spare_write);
        bit window_first;
        window_first = 1'($urandom_range(1));
        for (int k = 0; k < (spare_write ? 3 : 2); k++)
        begin
            if (k == 2)
            begin
                cfg_index <= CFG_SPARE;
                cfg_data  <= $urandom;
            end
            else if ((k == 0) == window_first)
            begin
                cfg_index <= CFG_WINDOW;
                cfg_data  <= window;
            end
            else
            begin
                cfg_index <= CFG_LIMIT;
                cfg_data  <= {27'($urandom), limit};
            end
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    initial
    begin
        logic [31:0] phase_window [PHASES];
        logic [4:0]  phase_limit  [PHASES];
        int          hot_ring     [HOT_RINGS];
        logic [31:0] clock_s;
        int          step_max;
        int          roll;
        int          ring;
        request_t    req;

        phase_window = '{32'hFFFF_FFFF, 32'd0, 32'd3, 32'd1, 32'd20, 32'd7,
                         32'($urandom_range(40)), $urandom, 32'd10};
        phase_limit  = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd20, 5'd3,
                         5'($urandom_range(31)), 5'($urandom_range(31)), 5'd5};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: window 10, limit 5; all four quadrants
        send_request(make_req(4'd0, 1'b0, 1'b0, 32'd100));
        send_request(make_req(4'd5, 1'b0, 1'b1, 32'd100));
        send_request(make_req(4'd10, 1'b1, 1'b0, 32'd100));
        send_request(make_req(4'd15, 1'b1, 1'b1, 32'd100));
        // fill one ring to the limit; the last one is refused
        for (int t = 101; t <= 105; t++)
            send_request(make_req(4'd15, 1'b1, 1'b1, 32'(t)));
        // oldest stamp just past the window, next one exactly at it
        send_request(make_req(4'd15, 1'b1, 1'b1, 32'd111));
        // time going backwards makes every stamp look ancient
        send_request(make_req(4'd15, 1'b1, 1'b1, 32'd50));
        // age across the 32-bit wrap
        send_request(make_req(4'd0, 1'b0, 1'b0, 32'hFFFF_FFFA));
        send_request(make_req(4'd0, 1'b0, 1'b0, 32'd3));
        wait_results();

        // zero window, zero limit: refused but stamps still expire
        load_settings(32'd0, 5'd0, 1'b1);
        send_request(make_req(4'd0, 1'b0, 1'b0, 32'd4));
        send_request(make_req(4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_request(make_req(4'd10, 1'b1, 1'b0, 32'd0));
        wait_results();

        for (int p = 0; p < PHASES; p++)
        begin
            load_settings(phase_window[p], phase_limit[p], 1'b0);
            idle_pct = (p == 2) ? 0 : 13;
            clock_s  = (p == 5) ? 32'hFFFF_FF00 : $urandom;
            step_max = (phase_window[p] >= 64) ? 40 : int'(phase_window[p]) / 3 + 1;
            for (int h = 0; h < HOT_RINGS; h++)
                hot_ring[h] = $urandom_range(RING_TOTAL - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    // noise: any ring, any time, often behind the clock
                    req = make_req(4'($urandom), 1'($urandom), 1'($urandom), $urandom);
                else
                begin
                    if (roll < 12)
                        clock_s += phase_window[p] + 32'($urandom_range(1000));
                    else
                        clock_s += 32'($urandom_range(step_max));
                    ring = (roll < 20) ? $urandom_range(RING_TOTAL - 1)
                                       : hot_ring[$urandom_range(HOT_RINGS - 1)];
                    req = make_req(4'(ring / 4), ring[1], ring[0], clock_s);
                end
                send_request(req);
                if (p == 4 && i == PHASE_ITEMS / 2)
                    wait_results();
            end
            wait_results();
        end

        repeat (40) @(posedge clk);
        $display("covered %0d requests under %0d register settings: %0d admitted, %0d refused",
                 sent, settings_count + 1, admitted, refused);
        $display("windows 0 to 2^32-1, limits 0 to 31, clock wrap and reversal, hot and cold rings");
        if (errors == 0 && pending == 0)
            $display("sliding_window_rate_limiter_top regression: pass");
        else
            $display("sliding_window_rate_limiter_top regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/swrl_pkg.sv
rtl/swrl_ram.sv
rtl/swrl_ctrl.sv
rtl/sliding_window_rate_limiter_top.sv
rtl/swrl_checker.sv
sim/admission_checker.sv
sim/tb_top.sv
